### sv/radix_integer_text_parser_core_macros.svh
// Assertion macros used by the checker file of the radix text parser.
`ifndef RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ritp assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ritp assertion failed");

`endif

### sv/ritp_pkg.sv
// Shared types, register indexes, character codes and helper functions of the parser.
package ritp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_RADIX              = 3'd0;
    localparam logic [2:0] REG_WIDTH_CODE         = 3'd1;
    localparam logic [2:0] REG_SIGNED_MODE        = 3'd2;
    localparam logic [2:0] REG_ALLOW_PLUS         = 3'd3;
    localparam logic [2:0] REG_ALLOW_LEADING_ZERO = 3'd4;

    // Character codes and the marker for a code unit that is no digit.
    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [7:0]  NO_DIGIT = 8'hFF;

    // Width codes.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    // Parse phase of the current string.
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    // Configuration registers as one group.
    typedef struct packed {
        logic [5:0] radix;
        logic [1:0] width_code;
        logic       signed_mode;
        logic       allow_plus;
        logic       allow_leading_zero;
    } cfg_t;

    // Per-string parse state.
    typedef struct packed {
        phase_t      phase;
        logic [63:0] acc;
        logic        negative;
        logic        failed;
        logic        first_zero;
    } parse_state_t;

    localparam cfg_t CFG_RESET = '{
        radix: 6'd10, width_code: WIDTH_64, signed_mode: 1'b1,
        allow_plus: 1'b0, allow_leading_zero: 1'b0
    };

    localparam parse_state_t STATE_CLEAR = '{
        phase: PH_START, acc: 64'd0, negative: 1'b0, failed: 1'b0, first_zero: 1'b0
    };

    // Digit value of a code unit, or NO_DIGIT.
    function automatic logic [7:0] digit_of(input logic [15:0] cu);
        logic [7:0] d;
        d = NO_DIGIT;
        if (cu >= 16'h0030 && cu <= 16'h0039) begin
            d = 8'(cu - 16'h0030);
        end else if (cu >= 16'h0061 && cu <= 16'h007A) begin
            d = 8'(cu - 16'h0061 + 16'd10);
        end else if (cu >= 16'h0041 && cu <= 16'h005A) begin
            d = 8'(cu - 16'h0041 + 16'd10);
        end
        return d;
    endfunction

    // All-ones mask of the selected result width.
    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WIDTH_8:  m = 64'h0000_0000_0000_00FF;
            WIDTH_16: m = 64'h0000_0000_0000_FFFF;
            WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Largest magnitude allowed for the selected width, mode and sign.
    function automatic logic [63:0] digit_limit(input logic [1:0] wc, input logic neg,
                                                input logic sgn);
        logic [63:0] half;
        logic [63:0] lim;
        case (wc)
            WIDTH_8:  half = 64'h0000_0000_0000_0080;
            WIDTH_16: half = 64'h0000_0000_0000_8000;
            WIDTH_32: half = 64'h0000_0000_8000_0000;
            default:  half = 64'h8000_0000_0000_0000;
        endcase
        if (neg) begin
            lim = half;
        end else if (sgn) begin
            lim = half - 64'd1;
        end else begin
            lim = width_mask(wc);
        end
        return lim;
    endfunction

endpackage

### sv/ritp_char_step.sv
// Next-state logic for one character: sign handling, digit decode and multiply-add check.
module ritp_char_step (
    input  ritp_pkg::cfg_t         cfg,
    input  ritp_pkg::parse_state_t cur,
    input  logic [15:0]            code_unit,
    output ritp_pkg::parse_state_t nxt
);
    import ritp_pkg::*;

    logic [7:0]  digit;
    logic [63:0] lim;
    logic [70:0] prod;
    logic [70:0] sum;

    // Digit decode and the exact acc * radix + digit product against the limit.
    always_comb
    begin
        digit = digit_of(code_unit);
        lim   = digit_limit(cfg.width_code, cur.negative, cfg.signed_mode);
        prod  = {7'd0, cur.acc} * {65'd0, cfg.radix};
        sum   = prod + {65'd0, digit[5:0]};
    end

    // State update for the character.
    always_comb
    begin
        nxt = cur;
        if (!cur.failed) begin
            if (cur.phase == PH_START && code_unit == CH_PLUS) begin
                if (cfg.allow_plus) begin
                    nxt.phase = PH_SIGN;
                end else begin
                    nxt.failed = 1'b1;
                end
            end else if (cur.phase == PH_START && code_unit == CH_MINUS) begin
                if (cfg.signed_mode) begin
                    nxt.negative = 1'b1;
                    nxt.phase    = PH_SIGN;
                end else begin
                    nxt.failed = 1'b1;
                end
            end else if (cur.first_zero && !cfg.allow_leading_zero) begin
                nxt.failed = 1'b1;
            end else if (digit >= {2'b00, cfg.radix}) begin
                nxt.failed = 1'b1;
            end else if (sum > {7'd0, lim}) begin
                nxt.failed = 1'b1;
            end else begin
                nxt.acc        = sum[63:0];
                nxt.first_zero = (cur.phase != PH_DIGITS) && (digit == 8'd0);
                nxt.phase      = PH_DIGITS;
            end
        end
    end

endmodule

### sv/radix_integer_text_parser_core.sv
// Top level of the radix integer text parser: handshakes, configuration and result register.
// The parser takes one UTF-16 code unit per cycle while in_ready is high. For the code unit
// marked last, the result (value, ok) is registered in the output register when that code unit
// leaves the input register. Each accepted code unit is registered in the input register,
// then the combinational multiply-add and range check on the accumulator retires it; that
// accumulator loop sets the rate of one code unit per clock, unless a last code unit is held.
// A last code unit waits in the input register only while the previous result is
// still held in the output register and not taken. Configuration writes are always accepted
// and apply to code units processed after the write.
module radix_integer_text_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value,
    output logic        ok,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import ritp_pkg::*;

    cfg_t         cfg_reg;
    logic         s1_valid_reg;
    logic [15:0]  s1_code_reg;
    logic         s1_last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [63:0]  value_reg;
    logic         ok_reg;
    logic         s1_advance;
    logic         in_fire;
    logic         result_fail;
    logic [63:0]  signed_value;

    // Configuration port: every write transaction completes at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RADIX:              cfg_reg.radix              <= cfg_data;
                REG_WIDTH_CODE:         cfg_reg.width_code         <= cfg_data[1:0];
                REG_SIGNED_MODE:        cfg_reg.signed_mode        <= cfg_data[0];
                REG_ALLOW_PLUS:         cfg_reg.allow_plus         <= cfg_data[0];
                REG_ALLOW_LEADING_ZERO: cfg_reg.allow_leading_zero <= cfg_data[0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Input stage: a code unit retires unless it is last and the result slot stays full.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_code_reg <= code_unit;
            s1_last_reg <= is_last;
        end
    end

    // Character processing.
    ritp_char_step u_step (
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .code_unit (s1_code_reg),
        .nxt       (step_next)
    );

    // Parse state: cleared after the last code unit of a string.
    always_comb
    begin
        state_next = state_reg;
        if (s1_advance) begin
            state_next = s1_last_reg ? STATE_CLEAR : step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Final value of a string: a sign alone or any error in it fails it.
    always_comb
    begin
        result_fail  = step_next.failed || (step_next.phase != PH_DIGITS);
        signed_value = step_next.negative ? (64'd0 - step_next.acc) : step_next.acc;
    end

    // Result register.
    assign out_valid_next = (out_valid_reg && !out_ready) || (s1_advance && s1_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg) begin
            value_reg <= result_fail ? 64'd0 : (signed_value & width_mask(cfg_reg.width_code));
            ok_reg    <= !result_fail;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign ok        = ok_reg;

endmodule

### sv/ritp_checker.sv
// Port-level assertions for the radix integer text parser and the bind that attaches them.
`include "radix_integer_text_parser_core_macros.svh"

module ritp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        is_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] value,
    input logic        ok,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A result held back by the consumer keeps its payload.
    `RITP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(value) && $stable(ok))

    // A failed string always reports a zero value.
    `RITP_ASSERT_NOW(a_fail_zero, out_valid && !ok, value == 64'd0)

    // A new result must trace back to an earlier last code unit transaction.
    `RITP_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && in_ready && is_last, 2))

    // Configuration write transactions never stall.
    `RITP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind radix_integer_text_parser_core ritp_checker u_ritp_checker (.*);
